FILE: rtl/sotf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sotf_pkg: shared types and constants of the second-order Tustin filter
// Transaction payloads, controller commands and status, and fixed widths.
// ----------------------------------------------------------------------------
package sotf_pkg;

    // Sample and coefficient width, and the Q8.24 time step.
    localparam int DATA_WIDTH = 32;
    localparam int TS_W       = 32;
    localparam int TS_FRAC    = 24;

    // Shared multiplier: A operand magnitude, B operand magnitude, digit size.
    localparam int MUL_AW    = (DATA_WIDTH > TS_W) ? DATA_WIDTH : TS_W;
    localparam int MUL_BW    = 64;
    localparam int MUL_DIGIT = 8;
    localparam int PROD_W    = MUL_AW + MUL_BW + 1;

    // Width of the exact numerators and the shared denominator.
    localparam int NUM_W = DATA_WIDTH + 65;

    // Accumulator of the difference equation.
    localparam int ACC_W = 2 * DATA_WIDTH + 3;

    // Five taps: input, input history 1 and 2, output history 1 and 2.
    localparam int          NUM_TAPS     = 5;
    localparam int          TAP_W        = 3;
    localparam logic [2:0]  TAP_LAST     = 3'd4;
    localparam logic [2:0]  TAP_FIRST_FB = 3'd3;

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_S2 = 3'd0,
        CFG_NUM_S1 = 3'd1,
        CFG_NUM_S0 = 3'd2,
        CFG_DEN_S2 = 3'd3,
        CFG_DEN_S1 = 3'd4,
        CFG_DEN_S0 = 3'd5
    } sotf_cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL_TT,
        ST_MUL_B1T,
        ST_MUL_A1T,
        ST_MUL_B0T2,
        ST_MUL_A0T2,
        ST_FORM,
        ST_DEN_CHECK,
        ST_DIVIDE,
        ST_FILTER,
        ST_ROUND,
        ST_DONE
    } sotf_state_t;

    typedef enum logic [2:0] {
        MOP_TT,
        MOP_B1T,
        MOP_A1T,
        MOP_B0T2,
        MOP_A0T2,
        MOP_TAP
    } sotf_mul_op_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] sample_in;
        logic signed [TS_W-1:0]       time_step;
    } sotf_in_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] sample_out;
        logic                         updated;
        logic                         saturated;
    } sotf_out_t;

    typedef struct packed {
        logic         load_in;
        logic         mul_start;
        sotf_mul_op_t mul_op;
        logic         div_start;
        logic [TAP_W-1:0] tap;
        logic         form_den;
        logic         hold;
        logic         commit;
        logic         out_load;
    } sotf_cmd_t;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic t_pos;
        logic den_zero;
    } sotf_status_t;

endpackage

FILE: rtl/sotf_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sotf_mul: shared sequential multiplier
// Sign and magnitude multiply, one 8-bit digit of the B operand per cycle.
// ----------------------------------------------------------------------------
module sotf_mul (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [sotf_pkg::MUL_AW-1:0]    a_mag,
    input  logic                           a_neg,
    input  logic [sotf_pkg::MUL_BW-1:0]    b_mag,
    input  logic                           b_neg,
    output logic signed [sotf_pkg::PROD_W-1:0] prod,
    output logic                           done
);
    import sotf_pkg::*;

    localparam int DIGITS = MUL_BW / MUL_DIGIT;
    localparam int CNT_W  = $clog2(DIGITS);
    localparam int MAG_W  = MUL_AW + MUL_BW;

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [MUL_AW-1:0] a_reg;
    logic [MUL_BW-1:0] b_reg;
    logic [MAG_W-1:0]  acc_reg;
    logic              neg_reg;
    logic [MAG_W-1:0]  acc_next;
    logic signed [PROD_W-1:0] mag_s;

    always_comb
    begin
        acc_next = (acc_reg << MUL_DIGIT)
                 + (MAG_W'(a_reg) * MAG_W'(b_reg[MUL_BW-1 -: MUL_DIGIT]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == '0);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIGITS - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                    busy_reg <= 1'b0;
                else
                    cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a_mag;
            b_reg   <= b_mag;
            acc_reg <= '0;
            neg_reg <= a_neg ^ b_neg;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            b_reg   <= b_reg << MUL_DIGIT;
        end
    end

    assign mag_s = signed'({1'b0, acc_reg});
    assign prod  = neg_reg ? -mag_s : mag_s;
    assign done  = done_reg;

endmodule

FILE: rtl/sotf_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sotf_div: restoring divider for the normalized coefficients
// One quotient bit per cycle, rounding half away from zero, then saturation.
// ----------------------------------------------------------------------------
module sotf_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic signed [sotf_pkg::NUM_W-1:0]     num,
    input  logic signed [sotf_pkg::NUM_W-1:0]     den,
    output logic signed [sotf_pkg::DATA_WIDTH-1:0] quot,
    output logic                                  done
);
    import sotf_pkg::*;

    localparam int DW   = DATA_WIDTH;
    localparam int RW   = 2 * DATA_WIDTH + FRAC_BITS + 65;
    localparam int CW   = $clog2(DW + 1);
    localparam logic [DW:0] POS_LIM = ((DW + 1)'(1) << (DW - 1)) - (DW + 1)'(1);
    localparam logic [DW:0] NEG_LIM = (DW + 1)'(1) << (DW - 1);
    localparam logic [DW-1:0] Q_MAX = {1'b0, {(DW - 1){1'b1}}};
    localparam logic [DW-1:0] Q_MIN = {1'b1, {(DW - 1){1'b0}}};

    logic          busy_reg;
    logic          last_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [RW-1:0] rem_reg;
    logic [RW-1:0] dsh_reg;
    logic [NUM_W-1:0] dabs_reg;
    logic [DW:0]   q_reg;
    logic          neg_reg;
    logic [DW-1:0] quot_reg;

    logic [NUM_W-1:0] num_mag;
    logic [NUM_W-1:0] den_mag;
    logic             ge;
    logic             rnd;
    logic [DW:0]      mag;
    logic             ovf;
    logic [DW-1:0]    sat_val;

    always_comb
    begin
        num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
        den_mag = den[NUM_W-1] ? NUM_W'(-den) : NUM_W'(den);
        ge      = rem_reg >= dsh_reg;
        rnd     = {rem_reg, 1'b0} >= (RW + 1)'(dabs_reg);
        mag     = (DW + 1)'(q_reg[DW-1:0]) + (DW + 1)'(rnd);
        ovf     = q_reg[DW];
        if (neg_reg)
            sat_val = (ovf || (mag > NEG_LIM)) ? Q_MIN : DW'(-mag);
        else
            sat_val = (ovf || (mag > POS_LIM)) ? Q_MAX : mag[DW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            last_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= last_reg;
            last_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DW);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    last_reg <= 1'b1;
                end
                else
                    cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= RW'(num_mag) << FRAC_BITS;
            dsh_reg  <= RW'(den_mag) << DW;
            dabs_reg <= den_mag;
            q_reg    <= '0;
            neg_reg  <= num[NUM_W-1] ^ den[NUM_W-1];
        end
        else if (busy_reg)
        begin
            if (ge)
                rem_reg <= rem_reg - dsh_reg;
            q_reg   <= {q_reg[DW-1:0], ge};
            dsh_reg <= dsh_reg >> 1;
        end
        if (last_reg)
            quot_reg <= sat_val;
    end

    assign quot = signed'(quot_reg);
    assign done = done_reg;

endmodule

FILE: rtl/sotf_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sotf_datapath: coefficient registers, history and arithmetic of the filter
// Holds the shared multiplier and divider and all item and result registers.
// ----------------------------------------------------------------------------
module sotf_datapath #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  sotf_pkg::sotf_cmd_t                   cmd,
    output sotf_pkg::sotf_status_t                status,
    input  sotf_pkg::sotf_in_t                    in_data,
    input  logic                                  cfg_we,
    input  logic [sotf_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [sotf_pkg::DATA_WIDTH-1:0]       cfg_data,
    output sotf_pkg::sotf_out_t                   out_data
);
    import sotf_pkg::*;

    localparam int D  = DATA_WIDTH;
    localparam int MW = ACC_W + 1;
    localparam logic [MW-1:0] HALF    = MW'(1) << (FRAC_BITS - 1);
    localparam logic [MW-1:0] POS_LIM = (MW'(1) << (D - 1)) - MW'(1);
    localparam logic [MW-1:0] NEG_LIM = MW'(1) << (D - 1);
    localparam logic [D-1:0]  Y_MAX   = {1'b0, {(D - 1){1'b1}}};
    localparam logic [D-1:0]  Y_MIN   = {1'b1, {(D - 1){1'b0}}};

    // Configuration and history
    logic signed [D-1:0] b2_reg, b1_reg, b0_reg, a2_reg, a1_reg, a0_reg;
    logic signed [D-1:0] u1_reg, u2_reg, y1_reg, y2_reg;

    // Per-transaction work registers
    logic signed [D-1:0]         u_reg;
    logic signed [TS_W-1:0]      t_reg;
    logic [MUL_BW-1:0]           t2_reg;
    logic signed [D+TS_W-1:0]    b1t_reg, a1t_reg;
    logic signed [NUM_W-1:0]     p3_reg, q3_reg, den_reg;
    logic signed [D-1:0]         c_reg [NUM_TAPS];
    logic signed [ACC_W-1:0]     acc_reg;
    logic signed [D-1:0]         y_reg;
    logic                        upd_reg;
    logic                        clip_reg;
    sotf_out_t                   out_reg;

    logic signed [NUM_W-1:0] p1, p2, q1, q2, den_sum, num_sel;
    logic signed [MUL_AW-1:0] a_sel;
    logic signed [MUL_BW-1:0] b_sel;
    logic [MUL_AW-1:0]        a_mag;
    logic [MUL_BW-1:0]        b_mag;
    logic signed [PROD_W-1:0] prod;
    logic                     mul_done;
    logic signed [D-1:0]      quot;
    logic                     div_done;
    logic signed [D-1:0]      hist_tap;
    logic signed [ACC_W-1:0]  prod_acc;

    logic [ACC_W-1:0] acc_mag;
    logic [MW-1:0]    rnd_m;
    logic             acc_neg;
    logic             y_clip;
    logic [D-1:0]     y_calc;

    // Numerator and denominator terms, all at scale 2^-(FRAC_BITS + 48).
    always_comb
    begin
        p1      = NUM_W'(b2_reg) <<< (2 * TS_FRAC + 2);
        p2      = NUM_W'(b1t_reg) <<< (TS_FRAC + 1);
        q1      = NUM_W'(a2_reg) <<< (2 * TS_FRAC + 2);
        q2      = NUM_W'(a1t_reg) <<< (TS_FRAC + 1);
        den_sum = q1 + q2 + q3_reg;
        case (cmd.tap)
            3'd0:    num_sel = p1 + p2 + p3_reg;
            3'd1:    num_sel = (p3_reg <<< 1) - (p1 <<< 1);
            3'd2:    num_sel = p1 - p2 + p3_reg;
            3'd3:    num_sel = (q3_reg <<< 1) - (q1 <<< 1);
            default: num_sel = q1 - q2 + q3_reg;
        endcase
    end

    always_comb
    begin
        case (cmd.tap)
            3'd0:    hist_tap = u_reg;
            3'd1:    hist_tap = u1_reg;
            3'd2:    hist_tap = u2_reg;
            3'd3:    hist_tap = y1_reg;
            default: hist_tap = y2_reg;
        endcase
        case (cmd.mul_op)
            MOP_TT:
            begin
                a_sel = MUL_AW'(t_reg);
                b_sel = MUL_BW'(t_reg);
            end
            MOP_B1T:
            begin
                a_sel = MUL_AW'(b1_reg);
                b_sel = MUL_BW'(t_reg);
            end
            MOP_A1T:
            begin
                a_sel = MUL_AW'(a1_reg);
                b_sel = MUL_BW'(t_reg);
            end
            MOP_B0T2:
            begin
                a_sel = MUL_AW'(b0_reg);
                b_sel = signed'(t2_reg);
            end
            MOP_A0T2:
            begin
                a_sel = MUL_AW'(a0_reg);
                b_sel = signed'(t2_reg);
            end
            default:
            begin
                a_sel = MUL_AW'(hist_tap);
                b_sel = MUL_BW'(c_reg[cmd.tap]);
            end
        endcase
        a_mag = a_sel[MUL_AW-1] ? MUL_AW'(-a_sel) : MUL_AW'(a_sel);
        b_mag = b_sel[MUL_BW-1] ? MUL_BW'(-b_sel) : MUL_BW'(b_sel);
    end

    sotf_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mul_start),
        .a_mag (a_mag),
        .a_neg (a_sel[MUL_AW-1]),
        .b_mag (b_mag),
        .b_neg (b_sel[MUL_BW-1]),
        .prod  (prod),
        .done  (mul_done)
    );

    sotf_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (num_sel),
        .den   (den_reg),
        .quot  (quot),
        .done  (div_done)
    );

    // Round the accumulated sum once, half away from zero, then clip.
    always_comb
    begin
        prod_acc = ACC_W'(prod);
        acc_neg  = acc_reg[ACC_W-1];
        acc_mag  = acc_neg ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
        rnd_m    = ({1'b0, acc_mag} + HALF) >> FRAC_BITS;
        y_clip   = acc_neg ? (rnd_m > NEG_LIM) : (rnd_m > POS_LIM);
        if (y_clip)
            y_calc = acc_neg ? Y_MIN : Y_MAX;
        else
            y_calc = acc_neg ? D'(-rnd_m) : rnd_m[D-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b2_reg <= '0;
            b1_reg <= '0;
            b0_reg <= '0;
            a2_reg <= '0;
            a1_reg <= '0;
            a0_reg <= '0;
            u1_reg <= '0;
            u2_reg <= '0;
            y1_reg <= '0;
            y2_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_NUM_S2: b2_reg <= signed'(cfg_data);
                    CFG_NUM_S1: b1_reg <= signed'(cfg_data);
                    CFG_NUM_S0: b0_reg <= signed'(cfg_data);
                    CFG_DEN_S2: a2_reg <= signed'(cfg_data);
                    CFG_DEN_S1: a1_reg <= signed'(cfg_data);
                    CFG_DEN_S0: a0_reg <= signed'(cfg_data);
                    default:    ;
                endcase
            end
            if (cmd.commit)
            begin
                u2_reg <= u1_reg;
                u1_reg <= u_reg;
                y2_reg <= y1_reg;
                y1_reg <= signed'(y_calc);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            u_reg   <= in_data.sample_in;
            t_reg   <= in_data.time_step;
            acc_reg <= '0;
        end
        if (mul_done)
        begin
            case (cmd.mul_op)
                MOP_TT:   t2_reg  <= prod[MUL_BW-1:0];
                MOP_B1T:  b1t_reg <= prod[D+TS_W-1:0];
                MOP_A1T:  a1t_reg <= prod[D+TS_W-1:0];
                MOP_B0T2: p3_reg  <= prod[NUM_W-1:0];
                MOP_A0T2: q3_reg  <= prod[NUM_W-1:0];
                default:
                begin
                    if (cmd.tap >= TAP_FIRST_FB)
                        acc_reg <= acc_reg - prod_acc;
                    else
                        acc_reg <= acc_reg + prod_acc;
                end
            endcase
        end
        if (cmd.form_den)
            den_reg <= den_sum;
        if (div_done)
            c_reg[cmd.tap] <= quot;
        if (cmd.hold)
        begin
            y_reg    <= y1_reg;
            upd_reg  <= 1'b0;
            clip_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            y_reg    <= signed'(y_calc);
            upd_reg  <= 1'b1;
            clip_reg <= y_clip;
        end
        if (cmd.out_load)
        begin
            out_reg.sample_out <= y_reg;
            out_reg.updated    <= upd_reg;
            out_reg.saturated  <= clip_reg;
        end
    end

    assign status.mul_done = mul_done;
    assign status.div_done = div_done;
    assign status.t_pos    = !t_reg[TS_W-1] && (t_reg != '0);
    assign status.den_zero = (den_reg == '0);
    assign out_data        = out_reg;

endmodule

FILE: rtl/sotf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sotf_ctrl: sequencer of the second-order Tustin filter
// Steps one transaction through products, divisions and the filter sum.
// ----------------------------------------------------------------------------
module sotf_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  logic                   out_stall,
    output sotf_pkg::sotf_cmd_t    cmd,
    input  sotf_pkg::sotf_status_t status
);
    import sotf_pkg::*;

    sotf_state_t      state_reg, state_next;
    logic             pend_reg, pend_next;
    logic [TAP_W-1:0] tap_reg, tap_next;
    logic             out_valid_reg, out_valid_next;
    sotf_state_t      mul_after;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pend_reg      <= 1'b0;
            tap_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            tap_reg       <= tap_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pend_next  = pend_reg;
        tap_next   = tap_reg;
        cmd        = '0;
        cmd.tap    = tap_reg;

        case (state_reg)
            ST_MUL_B1T:  begin cmd.mul_op = MOP_B1T;  mul_after = ST_MUL_A1T;  end
            ST_MUL_A1T:  begin cmd.mul_op = MOP_A1T;  mul_after = ST_MUL_B0T2; end
            ST_MUL_B0T2: begin cmd.mul_op = MOP_B0T2; mul_after = ST_MUL_A0T2; end
            ST_MUL_A0T2: begin cmd.mul_op = MOP_A0T2; mul_after = ST_FORM;     end
            ST_FILTER:   begin cmd.mul_op = MOP_TAP;  mul_after = ST_ROUND;    end
            default:     begin cmd.mul_op = MOP_TT;   mul_after = ST_MUL_B1T;  end
        endcase

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (!status.t_pos)
                begin
                    cmd.hold   = 1'b1;
                    state_next = ST_DONE;
                end
                else
                    state_next = ST_MUL_TT;
            end
            ST_MUL_TT, ST_MUL_B1T, ST_MUL_A1T, ST_MUL_B0T2, ST_MUL_A0T2:
            begin
                if (!pend_reg)
                begin
                    cmd.mul_start = 1'b1;
                    pend_next     = 1'b1;
                end
                else if (status.mul_done)
                begin
                    pend_next  = 1'b0;
                    state_next = mul_after;
                end
            end
            ST_FORM:
            begin
                cmd.form_den = 1'b1;
                state_next   = ST_DEN_CHECK;
            end
            ST_DEN_CHECK:
            begin
                tap_next = '0;
                if (status.den_zero)
                begin
                    cmd.hold   = 1'b1;
                    state_next = ST_DONE;
                end
                else
                    state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (!pend_reg)
                begin
                    cmd.div_start = 1'b1;
                    pend_next     = 1'b1;
                end
                else if (status.div_done)
                begin
                    pend_next = 1'b0;
                    if (tap_reg == TAP_LAST)
                    begin
                        tap_next   = '0;
                        state_next = ST_FILTER;
                    end
                    else
                        tap_next = tap_reg + 1'b1;
                end
            end
            ST_FILTER:
            begin
                if (!pend_reg)
                begin
                    cmd.mul_start = 1'b1;
                    pend_next     = 1'b1;
                end
                else if (status.mul_done)
                begin
                    pend_next = 1'b0;
                    if (tap_reg == TAP_LAST)
                        state_next = mul_after;
                    else
                        tap_next = tap_reg + 1'b1;
                end
            end
            ST_ROUND:
            begin
                cmd.commit = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase

        out_valid_next = cmd.out_load || (out_valid_reg && out_stall);
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    // A unit completion is only expected while the sequencer waits on it.
    assert property (@(posedge clk) disable iff (!rst_n)
        status.mul_done |-> (pend_reg && (state_reg == ST_MUL_TT
            || state_reg == ST_MUL_B1T || state_reg == ST_MUL_A1T
            || state_reg == ST_MUL_B0T2 || state_reg == ST_MUL_A0T2
            || state_reg == ST_FILTER)))
        else $error("multiplier finished with no product pending");

    assert property (@(posedge clk) disable iff (!rst_n)
        status.div_done |-> (pend_reg && state_reg == ST_DIVIDE))
        else $error("divider finished outside the division phase");

    // A waiting result must never be overwritten.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || !out_stall))
        else $error("result register loaded while a stalled result waits");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.mul_start || cmd.div_start) |=> pend_reg)
        else $error("unit start not tracked as pending");

endmodule

FILE: rtl/second_order_tustin_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// second_order_tustin_filter: bilinear-transform second-order IIR filter
// Discretizes (b2 s^2 + b1 s + b0) / (a2 s^2 + a1 s + a0) for each sample.
// ----------------------------------------------------------------------------
// Usage. Write the six Q16.16 coefficients on the cfg port (index 0..5 is
// num s^2, num s, num constant, den s^2, den s, den constant) while the block
// is idle. Each input transaction on sample carries one Q16.16 sample and a
// Q8.24 time step; each one produces exactly one result transaction.
// The block works on one transaction at a time. When the time step is
// positive, it forms t^2 and four scaled products, builds the shared
// denominator, runs five restoring divisions and five filter products on a
// shared 8-bit-digit multiplier. The five divisions dominate the time
// of an update from acceptance to result. A zero or negative step
// returns the held output with updated low. A zero denominator is only
// known after t^2 and the four scaled products, so that case returns the
// held output only after them, with updated low. The next sample is taken
// the cycle after the result enters the output register, even if the
// receiver is stalling; the finished result waits there, unchanged, until
// it is taken.
// Reset clears the coefficients, the history and all handshake state.
// ----------------------------------------------------------------------------
module second_order_tustin_filter #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                sample_valid,
    output logic                                sample_stall,
    input  sotf_pkg::sotf_in_t                  sample,
    output logic                                result_valid,
    input  logic                                result_stall,
    output sotf_pkg::sotf_out_t                 result,
    input  logic                                cfg_we,
    input  logic [sotf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sotf_pkg::DATA_WIDTH-1:0]     cfg_data
);
    import sotf_pkg::*;

    sotf_cmd_t    cmd;
    sotf_status_t status;

    // The sequencer owns the handshakes and the order of operations.
    sotf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample_valid),
        .in_stall  (sample_stall),
        .out_valid (result_valid),
        .out_stall (result_stall),
        .cmd       (cmd),
        .status    (status)
    );

    // The datapath holds all arithmetic, coefficients and filter history.
    sotf_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (sample),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_data  (result)
    );

endmodule
